### rtl/ace_pkg.sv
// ----------------------------------------------------------------------------
// ace_pkg: shared constants and helpers for the arc-cosine kernel evaluator
// Fixed-point constants in Q30, element and accumulator widths, CORDIC table.
// ----------------------------------------------------------------------------
package ace_pkg;

    localparam int ELEM_W   = 16;
    localparam int ACC_W    = 48;
    localparam int KVAL_W   = 32;
    localparam int LAYER_W  = 4;
    localparam int CW       = 36;   // CORDIC datapath width
    localparam int STEPS    = 30;

    localparam logic [3:0] LAYERS_RST = 4'd1;

    localparam logic signed [CW-1:0] ONE_Q30     = 36'sd1073741824;
    localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;
    localparam logic [31:0]          ONE_DPI_Q30 = 32'd341782638;

    localparam logic [ACC_W:0] SQ_MAX  = 49'h0_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W:0] DOT_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W:0] DOT_MIN = -49'sh0_7FFF_FFFF_FFFF;

    // Arctangent of 2^-i in Q30.
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd843314857;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043837;
            5'd3:  v = 32'd133525159;
            5'd4:  v = 32'd67021687;
            5'd5:  v = 32'd33543516;
            5'd6:  v = 32'd16775851;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194283;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048576;
            5'd11: v = 32'd524288;
            5'd12: v = 32'd262144;
            5'd13: v = 32'd131072;
            5'd14: v = 32'd65536;
            5'd15: v = 32'd32768;
            5'd16: v = 32'd16384;
            5'd17: v = 32'd8192;
            5'd18: v = 32'd4096;
            5'd19: v = 32'd2048;
            5'd20: v = 32'd1024;
            5'd21: v = 32'd512;
            5'd22: v = 32'd256;
            5'd23: v = 32'd128;
            5'd24: v = 32'd64;
            5'd25: v = 32'd32;
            5'd26: v = 32'd16;
            5'd27: v = 32'd8;
            5'd28: v = 32'd4;
            5'd29: v = 32'd2;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Arithmetic shift right, rounding toward zero.
    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                     input logic [4:0] s);
        logic [CW-1:0] mag;
        logic [CW-1:0] m;
        mag = v[CW-1] ? CW'(-v) : CW'(v);
        m   = mag >> s;
        return v[CW-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

### rtl/ace_if.sv
// ----------------------------------------------------------------------------
// ace_if: stream channels of the arc-cosine kernel evaluator
// Element-pair input channel and kernel result channel, valid/ready.
// ----------------------------------------------------------------------------
interface ace_in_if;
    logic                      valid;
    logic                      ready;
    logic signed [15:0]        first_elem;
    logic signed [15:0]        second_elem;
    logic                      last_elem;
    modport source (output valid, first_elem, second_elem, last_elem, input ready);
    modport sink   (input valid, first_elem, second_elem, last_elem, output ready);
endinterface

interface ace_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] kernel_value;
    logic        zero_norm;
    logic        saturated;
    modport source (output valid, kernel_value, zero_norm, saturated, input ready);
    modport sink   (input valid, kernel_value, zero_norm, saturated, output ready);
endinterface

### rtl/arc_cosine_kernel_eval.sv
// Each non-last element pair is accepted, then accumulated. A last pair then runs
// to the output register through two 32-step square roots, a 30-step divide
// (skipped when |cos| saturates at one), then layers + 1 passes of a 32-step root,
// two 30-step CORDIC passes and the control states ACS, ACQ, SCS, JM, JS, JD, JR.
// Input is held off until each pair is accumulated, and during the finish.
// Reset (synchronous, active low): sums cleared, layers = 1, no result pending.
// ----------------------------------------------------------------------------
// arc_cosine_kernel_eval: degree-1 multilayer arc-cosine kernel
// Accumulates dot product and squared norms, then runs a sequencer over one
// shared multiplier, a bit-pair square root, a restoring divider and a CORDIC.
// ----------------------------------------------------------------------------
module arc_cosine_kernel_eval (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [ace_pkg::LAYER_W-1:0] i_cfg_wr_data,
    ace_in_if.sink                      i_in,
    ace_out_if.source                   o_out
);
    import ace_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_ACC, S_CHK, S_SQRT, S_PROD, S_DIVI, S_DIV, S_ACS, S_ACQ,
        S_VEC, S_SCS, S_ROT, S_JM, S_JS, S_JD, S_JR, S_KH, S_KL, S_KS, S_OUT
    } t_state;

    typedef enum logic [1:0] {SR_X, SR_Y, SR_AC} t_sqret;

    localparam logic [63:0] BIT0  = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ONE60 = 64'h1000_0000_0000_0000;

    t_state r_state;
    t_sqret r_sqret;

    logic [LAYER_W-1:0] r_layers, r_lcnt;

    // element pair of the accepted transaction
    logic signed [ELEM_W-1:0] r_a, r_b;
    logic                     r_last;

    // running sums
    logic signed [ACC_W-1:0] r_dot;
    logic [ACC_W-1:0]        r_sqx, r_sqy;

    // square root unit
    logic [63:0] r_sq_v, r_sq_r, r_bit;
    logic [31:0] r_nx, r_ny;

    // divider
    logic [61:0] r_prod;
    logic [63:0] r_div_r;
    logic [30:0] r_q;
    logic signed [31:0] r_c;

    // CORDIC
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic [4:0]           r_i;
    logic [31:0]          r_theta;
    logic                 r_upper;
    logic signed [31:0]   r_sn, r_cs;

    // layer ratio and kernel
    logic [32:0] r_j;
    logic [30:0] r_f;
    logic [63:0] r_khi;

    // shared multiplier
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] r_mul;

    // finished result waiting for the output register
    logic [KVAL_W-1:0] r_res_kv;
    logic              r_res_zn, r_res_sat;

    // output register
    logic              r_ovalid;
    logic [KVAL_W-1:0] r_kv;
    logic              r_zn, r_sat;

    // ---------------- accumulation ----------------
    logic signed [31:0]    p_aa, p_bb, p_ab;
    logic [ACC_W:0]        s_x, s_y;
    logic signed [ACC_W:0] s_d;
    logic [ACC_W-1:0]      n_sqx, n_sqy;
    logic signed [ACC_W-1:0] n_dot;

    always_comb begin
        p_aa  = r_a * r_a;
        p_bb  = r_b * r_b;
        p_ab  = r_a * r_b;
        s_x   = {1'b0, r_sqx} + (ACC_W+1)'(unsigned'(p_aa));
        s_y   = {1'b0, r_sqy} + (ACC_W+1)'(unsigned'(p_bb));
        s_d   = {r_dot[ACC_W-1], r_dot} + (ACC_W+1)'(p_ab);
        n_sqx = (s_x > SQ_MAX) ? SQ_MAX[ACC_W-1:0] : s_x[ACC_W-1:0];
        n_sqy = (s_y > SQ_MAX) ? SQ_MAX[ACC_W-1:0] : s_y[ACC_W-1:0];
        if (s_d > DOT_MAX) begin
            n_dot = DOT_MAX[ACC_W-1:0];
        end else if (s_d < DOT_MIN) begin
            n_dot = DOT_MIN[ACC_W-1:0];
        end else begin
            n_dot = s_d[ACC_W-1:0];
        end
    end

    // ---------------- square root step ----------------
    logic [63:0] sq_t, n_v, n_root;
    logic        sq_ge;

    always_comb begin
        sq_t   = r_sq_r + r_bit;
        sq_ge  = r_sq_v >= sq_t;
        n_v    = sq_ge ? r_sq_v - sq_t : r_sq_v;
        n_root = sq_ge ? (r_sq_r >> 1) + r_bit : r_sq_r >> 1;
    end

    // ---------------- divider step ----------------
    logic [46:0] dot_abs;
    logic [63:0] d_num, dv_sh, n_div_r;
    logic        dv_ge;
    logic [30:0] n_q;

    always_comb begin
        dot_abs = r_dot[ACC_W-1] ? 47'(-r_dot) : r_dot[46:0];
        d_num   = {3'b0, dot_abs, 14'b0};
        dv_sh   = {r_div_r[62:0], 1'b0};
        dv_ge   = dv_sh >= {2'b0, r_prod};
        n_div_r = dv_ge ? dv_sh - {2'b0, r_prod} : dv_sh;
        n_q     = {r_q[29:0], dv_ge};
    end

    // ---------------- CORDIC step ----------------
    // Rotation drives z to zero, vectoring drives y to zero.
    logic signed [CW-1:0] c_dx, c_dy, n_x, n_y, n_z, c_at;
    logic                 c_up;

    always_comb begin
        c_dx = shr_tz(r_y, r_i);
        c_dy = shr_tz(r_x, r_i);
        c_at = $signed(CW'(atan_q30(r_i)));
        c_up = (r_state == S_ROT) ? !r_z[CW-1] : r_y[CW-1];
        if (c_up) begin
            n_x = r_x - c_dx;
            n_y = r_y + c_dy;
            n_z = r_z - c_at;
        end else begin
            n_x = r_x + c_dx;
            n_y = r_y - c_dy;
            n_z = r_z + c_at;
        end
    end

    // clamped results of the last CORDIC step
    logic signed [CW-1:0] cl_x, cl_y, cl_z;
    logic [31:0]          c_abs, cs_abs;

    always_comb begin
        cl_x = (n_x > ONE_Q30) ? ONE_Q30 : ((n_x < -ONE_Q30) ? -ONE_Q30 : n_x);
        cl_y = (n_y > ONE_Q30) ? ONE_Q30 : ((n_y < -ONE_Q30) ? -ONE_Q30 : n_y);
        cl_z = n_z[CW-1] ? '0 : ((n_z > PI_Q30) ? PI_Q30 : n_z);
        c_abs  = r_c[31]  ? 32'(-r_c)  : 32'(r_c);
        cs_abs = r_cs[31] ? 32'(-r_cs) : 32'(r_cs);
    end

    // ---------------- layer ratio and kernel ----------------
    logic signed [CW-1:0] j_m, j_sum;
    logic [34:0]          f_raw;
    logic [30:0]          f_val;
    logic [63:0]          k_scaled;
    logic [43:0]          k_val;

    always_comb begin
        j_m      = $signed({2'b0, r_mul[63:30]});
        j_sum    = CW'(r_sn) + (r_cs[31] ? -j_m : j_m);
        f_raw    = r_mul[64:30];
        f_val    = (f_raw > 35'(ONE_Q30)) ? ONE_Q30[30:0] : f_raw[30:0];
        k_scaled = r_khi + {30'b0, r_mul[63:30]};
        k_val    = k_scaled[63:20];
    end

    // ---------------- shared multiplier operand select ----------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_PROD: begin
                mul_a = {1'b0, r_nx};
                mul_b = r_ny;
            end
            S_ACS: begin
                mul_a = {1'b0, c_abs};
                mul_b = c_abs;
            end
            S_JM: begin
                mul_a = {1'b0, PI_Q30[31:0] - r_theta};
                mul_b = cs_abs;
            end
            S_JD: begin
                mul_a = r_j;
                mul_b = ONE_DPI_Q30;
            end
            S_KH: begin
                mul_a = {3'b0, r_prod[61:32]};
                mul_b = {1'b0, r_f};
            end
            S_KL: begin
                mul_a = {1'b0, r_prod[31:0]};
                mul_b = {1'b0, r_f};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // hold off input while in reset so no transaction is taken and lost
    assign i_in.ready         = (r_state == S_IDLE) && i_rst_n;
    assign o_out.valid        = r_ovalid;
    assign o_out.kernel_value = r_kv;
    assign o_out.zero_norm    = r_zn;
    assign o_out.saturated    = r_sat;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sqret  <= SR_X;
            r_layers <= LAYERS_RST;
            r_lcnt   <= '0;
            r_dot    <= '0;
            r_sqx    <= '0;
            r_sqy    <= '0;
            r_ovalid <= 1'b0;
            r_i      <= '0;
        end else begin
            r_mul <= mul_a * mul_b;

            if (i_cfg_wr_en) begin
                r_layers <= i_cfg_wr_data;
            end

            // drop the result once the sink takes the transaction; the output
            // state reloads the register itself
            if (r_ovalid && o_out.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_a     <= i_in.first_elem;
                        r_b     <= i_in.second_elem;
                        r_last  <= i_in.last_elem;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sqx   <= n_sqx;
                    r_sqy   <= n_sqy;
                    r_dot   <= n_dot;
                    r_state <= r_last ? S_CHK : S_IDLE;
                end
                S_CHK: begin
                    r_lcnt <= r_layers;
                    if (r_sqx == '0 || r_sqy == '0) begin
                        r_res_kv  <= '0;
                        r_res_zn  <= 1'b1;
                        r_res_sat <= 1'b0;
                        r_state   <= S_OUT;
                    end else begin
                        r_sq_v  <= {2'b0, r_sqx, 14'b0};
                        r_sq_r  <= '0;
                        r_bit   <= BIT0;
                        r_sqret <= SR_X;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_bit[0]) begin
                        unique case (r_sqret)
                            SR_X: begin
                                r_nx    <= n_root[31:0];
                                r_sq_v  <= {2'b0, r_sqy, 14'b0};
                                r_sq_r  <= '0;
                                r_bit   <= BIT0;
                                r_sqret <= SR_Y;
                            end
                            SR_Y: begin
                                r_ny    <= n_root[31:0];
                                r_state <= S_PROD;
                            end
                            SR_AC: begin
                                // pre-rotate by pi/2 for a negative cosine
                                if (r_c[31]) begin
                                    r_x <= $signed(n_root[CW-1:0]);
                                    r_y <= -CW'(r_c);
                                    r_z <= HALF_PI_Q30;
                                end else begin
                                    r_x <= CW'(r_c);
                                    r_y <= $signed(n_root[CW-1:0]);
                                    r_z <= '0;
                                end
                                r_i     <= '0;
                                r_state <= S_VEC;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end else begin
                        r_sq_v <= n_v;
                        r_sq_r <= n_root;
                        r_bit  <= r_bit >> 2;
                    end
                end
                S_PROD: begin
                    r_state <= S_DIVI;
                end
                S_DIVI: begin
                    r_prod <= r_mul[61:0];
                    if (d_num >= r_mul[63:0]) begin
                        // cosine saturates at magnitude one
                        r_c     <= r_dot[ACC_W-1] ? -32'sd1073741824 : 32'sd1073741824;
                        r_state <= S_ACS;
                    end else begin
                        r_div_r <= d_num;
                        r_q     <= '0;
                        r_i     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div_r <= n_div_r;
                    r_q     <= n_q;
                    r_i     <= r_i + 5'd1;
                    if (r_i == 5'(STEPS - 1)) begin
                        r_c     <= r_dot[ACC_W-1] ? -$signed({1'b0, n_q})
                                                  : $signed({1'b0, n_q});
                        r_state <= S_ACS;
                    end
                end
                S_ACS: begin
                    r_state <= S_ACQ;
                end
                S_ACQ: begin
                    r_sq_v  <= ONE60 - r_mul[63:0];
                    r_sq_r  <= '0;
                    r_bit   <= BIT0;
                    r_sqret <= SR_AC;
                    r_state <= S_SQRT;
                end
                S_VEC: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(STEPS - 1)) begin
                        r_theta <= cl_z[31:0];
                        r_state <= S_SCS;
                    end
                end
                S_SCS: begin
                    // fold the upper half of [0, pi] down by pi/2
                    r_upper <= r_theta > HALF_PI_Q30[31:0];
                    r_z     <= (r_theta > HALF_PI_Q30[31:0])
                               ? CW'(r_theta) - HALF_PI_Q30 : CW'(r_theta);
                    r_x     <= GAIN_Q30;
                    r_y     <= '0;
                    r_i     <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(STEPS - 1)) begin
                        if (r_upper) begin
                            r_sn <= cl_x[31:0];
                            r_cs <= 32'(-cl_y);
                        end else begin
                            r_sn <= cl_y[31:0];
                            r_cs <= cl_x[31:0];
                        end
                        r_state <= S_JM;
                    end
                end
                S_JM: begin
                    r_state <= S_JS;
                end
                S_JS: begin
                    r_j     <= j_sum[CW-1] ? '0 : j_sum[32:0];
                    r_state <= S_JD;
                end
                S_JD: begin
                    r_state <= S_JR;
                end
                S_JR: begin
                    r_f <= f_val;
                    if (r_lcnt != '0) begin
                        // feed the ratio back through acos for the next layer
                        r_lcnt  <= r_lcnt - 1'b1;
                        r_c     <= $signed({1'b0, f_val});
                        r_state <= S_ACS;
                    end else begin
                        r_state <= S_KH;
                    end
                end
                S_KH: begin
                    r_state <= S_KL;
                end
                S_KL: begin
                    r_khi   <= {r_mul[61:0], 2'b0};
                    r_state <= S_KS;
                end
                S_KS: begin
                    r_res_zn <= 1'b0;
                    if (k_val[43:32] != '0) begin
                        r_res_kv  <= '1;
                        r_res_sat <= 1'b1;
                    end else begin
                        r_res_kv  <= k_val[31:0];
                        r_res_sat <= 1'b0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free, then clear sums
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_kv     <= r_res_kv;
                        r_zn     <= r_res_zn;
                        r_sat    <= r_res_sat;
                        r_dot    <= '0;
                        r_sqx    <= '0;
                        r_sqy    <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### tb/arc_cosine_kernel_eval_tb.sv
// ----------------------------------------------------------------------------
// arc_cosine_kernel_eval_tb: self-checking bench for the arc-cosine kernel
// Streams element pairs with random gaps and output stalls, predicts each
// kernel result with a bit-exact fixed-point model and checks every field.
// ----------------------------------------------------------------------------
module arc_cosine_kernel_eval_tb;
    import ace_pkg::*;

    typedef struct packed {
        logic [31:0] kernel_value;
        logic        zero_norm;
        logic        saturated;
    } t_kernel_res;

    // Kernel predictor plus a queue of pending results.
    class t_kernel_board;
        logic [3:0]         layer_cnt;
        longint             dot_acc;
        longint             x_sq_acc;
        longint             y_sq_acc;
        t_kernel_res        pending[$];
        int                 err_cnt;

        function new();
            layer_cnt = LAYERS_RST;
            clear_sums();
            err_cnt = 0;
        endfunction

        function void clear_sums();
            dot_acc = 0;
            x_sq_acc = 0;
            y_sq_acc = 0;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint shift_tz(longint v, int s);
            if (v < 0) return -(longint'((-v) >>> s));
            return v >>> s;
        endfunction

        function longint qmul(longint a, longint b);
            longint unsigned m;
            m = (longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b)) >> 30;
            return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint angle_of(longint c);
            longint x, y, z, t, dx, dy;
            z = 0;
            c = clip(c, -64'sd1073741824, 64'sd1073741824);
            x = c;
            y = longint'(int_sqrt((64'd1 << 60) - longint'(c * c)));
            if (x < 0) begin
                t = x;
                x = y;
                y = -t;
                z = HALF_PI_Q30;
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = shift_tz(y, i);
                dy = shift_tz(x, i);
                if (y >= 0) begin
                    x += dx; y -= dy; z += atan_q30(5'(i));
                end else begin
                    x -= dx; y += dy; z -= atan_q30(5'(i));
                end
            end
            return clip(z, 0, PI_Q30);
        endfunction

        // J(t)/pi in Q30, kept within [0, 1]
        function longint layer_ratio(longint t);
            longint x, y, z, dx, dy, sn, cs, j;
            bit upper;
            x = GAIN_Q30;
            y = 0;
            upper = t > HALF_PI_Q30;
            z = upper ? t - HALF_PI_Q30 : t;
            for (int i = 0; i < STEPS; i++) begin
                dx = shift_tz(y, i);
                dy = shift_tz(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_q30(5'(i));
                end else begin
                    x += dx; y -= dy; z += atan_q30(5'(i));
                end
            end
            x = clip(x, -64'sd1073741824, 64'sd1073741824);
            y = clip(y, -64'sd1073741824, 64'sd1073741824);
            sn = upper ? x : y;
            cs = upper ? -y : x;
            j = sn + qmul(PI_Q30 - t, cs);
            if (j < 0) j = 0;
            j = (j * longint'(ONE_DPI_Q30)) >>> 30;
            return j > (64'sd1 << 30) ? (64'sd1 << 30) : j;
        endfunction

        // Note one accepted element pair; queue a result on the last one.
        function void note_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
            longint unsigned nx, ny, p, d, q, r, ph, pl, scaled, val;
            longint cosv, theta, f;
            t_kernel_res res;
            x_sq_acc = clip(x_sq_acc + longint'(a) * a, 0, (64'sd1 << 48) - 1);
            y_sq_acc = clip(y_sq_acc + longint'(b) * b, 0, (64'sd1 << 48) - 1);
            dot_acc = clip(dot_acc + longint'(a) * b, -((64'sd1 << 47) - 1),
                           (64'sd1 << 47) - 1);
            if (!last) return;
            res = '0;
            if (x_sq_acc == 0 || y_sq_acc == 0) begin
                res.zero_norm = 1'b1;
            end else begin
                nx = int_sqrt(longint'(x_sq_acc) << 14);
                ny = int_sqrt(longint'(y_sq_acc) << 14);
                p = nx * ny;
                d = longint'(dot_acc < 0 ? -dot_acc : dot_acc) << 14;
                if (d >= p) begin
                    q = 64'd1 << 30;
                end else begin
                    r = d;
                    q = 0;
                    for (int i = 0; i < 30; i++) begin
                        r <<= 1;
                        q <<= 1;
                        if (r >= p) begin
                            r -= p;
                            q |= 1;
                        end
                    end
                end
                cosv = dot_acc < 0 ? -longint'(q) : longint'(q);
                theta = angle_of(cosv);
                for (int i = 0; i < layer_cnt; i++) theta = angle_of(layer_ratio(theta));
                f = layer_ratio(theta);
                ph = p >> 32;
                pl = p & 64'hFFFF_FFFF;
                scaled = ((ph * f) << 2) + ((pl * f) >> 30);
                val = scaled >> 20;
                if (val > 64'hFFFF_FFFF) begin
                    res.kernel_value = 32'hFFFF_FFFF;
                    res.saturated = 1'b1;
                end else begin
                    res.kernel_value = val[31:0];
                end
            end
            pending.push_back(res);
            clear_sums();
        endfunction

        function void check_result(t_kernel_res got);
            t_kernel_res exp_r;
            if (pending.size() == 0) begin
                $error("result with no pending prediction");
                err_cnt++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.kernel_value !== exp_r.kernel_value) begin
                $error("kernel_value exp %0d got %0d", exp_r.kernel_value, got.kernel_value);
                err_cnt++;
            end
            if (got.zero_norm !== exp_r.zero_norm) begin
                $error("zero_norm exp %0b got %0b", exp_r.zero_norm, got.zero_norm);
                err_cnt++;
            end
            if (got.saturated !== exp_r.saturated) begin
                $error("saturated exp %0b got %0b", exp_r.saturated, got.saturated);
                err_cnt++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [3:0] i_cfg_wr_data = '0;
    int         cycle_cnt = 0;
    bit         calm_mode = 1'b0;  // no idling on either side
    bit         hold_req = 1'b0;   // driver asks for one long receiver stall
    bit         hold_seen = 1'b0;  // receiver has started that stall
    int         hold_off = 0;      // receiver stall cycles left
    t_kernel_board board;

    ace_in_if  in_ch();
    ace_out_if out_ch();

    arc_cosine_kernel_eval uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in         (in_ch.sink),
        .o_out        (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: ends the run with an error report if the cycle counter passes its limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 10000000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off counted here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                board.check_result('{out_ch.kernel_value, out_ch.zero_norm,
                                     out_ch.saturated});
            if (hold_req && !hold_seen) begin
                hold_seen <= 1'b1;
                hold_off <= 2500;
                out_ch.ready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm_mode || ($urandom_range(99) >= 37);
            end
        end
    end

    // Offer one element pair; hold it until taken. Valid stays up on return
    // so the next pair can follow at once; callers that pause drop it.
    task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
        while (!calm_mode && $urandom_range(99) < 37) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.first_elem <= a;
        in_ch.second_elem <= b;
        in_ch.last_elem <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_pair(a, b, last);
    endtask

    // Drain results, then write the layer count while idle.
    task automatic set_layers(logic [3:0] n);
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= n;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.layer_cnt = n;
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3: return 16'($signed($urandom_range(255)) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    // Vector of random length; mostly short, sometimes correlated.
    task automatic send_vector(output int len);
        int mode;
        logic signed [15:0] a, b;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
        mode = $urandom_range(3);
        for (int k = 0; k < len; k++) begin
            a = rand_elem();
            case (mode)
                0: b = a;
                1: b = -a;
                2: b = (a == 16'sh8000) ? a : 16'(a + $signed($urandom_range(64)) - 32);
                default: b = rand_elem();
            endcase
            send_pair(a, b, k == len - 1);
        end
    endtask

    initial begin
        int sent;
        int n;
        in_ch.valid = 1'b0;
        in_ch.first_elem = '0;
        in_ch.second_elem = '0;
        in_ch.last_elem = 1'b0;
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, zero norms, orthogonal, opposite.
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sh0000, 16'sh1234, 1'b1);
        send_pair(16'sh4000, 16'sh0000, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sh4000, 16'sh0000, 1'b0);
        send_pair(16'sh0000, 16'sh4000, 1'b1);
        send_pair(16'sh0001, 16'shFFFF, 1'b1);
        send_pair(16'sh5555, 16'shAAAA, 1'b0);
        send_pair(16'sh2AAA, 16'sh1555, 1'b1);
        set_layers(4'd0);
        send_pair(16'sh3000, 16'sh1000, 1'b1);
        set_layers(4'd15);
        send_pair(16'sh3000, 16'shE000, 1'b1);
        send_pair(16'sh7FFF, 16'sh8000, 1'b1);
        set_layers(4'd1);

        // Pressure: hold the receiver off while vectors keep coming.
        hold_req = 1'b1;
        for (int v = 0; v < 4; v++) send_vector(n);

        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            set_layers(ph == 5 ? 4'd15 : ph == 0 ? 4'd0 : 4'($urandom_range(15)));
            calm_mode = (ph == 2);
            while (sent < (ph + 1) * 145) begin
                send_vector(n);
                sent = sent + n;
            end
        end
        calm_mode = 1'b0;
        in_ch.valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.err_cnt == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
